>>> rtl/mmc_pkg.sv
`timescale 1ns / 1ps

package mmc_pkg;

  // Field widths
  localparam int unsigned InstrW = 32;
  localparam int unsigned CwW    = 21;
  localparam int unsigned AluW   = 3;
  localparam int unsigned StateW = 4;
  localparam int unsigned OpW    = 6;

  localparam int unsigned RomDepth = 10;

  typedef logic [StateW-1:0] state_t;
  typedef logic [CwW-1:0]    cw_t;
  typedef logic [AluW-1:0]   alu_t;
  typedef logic [OpW-1:0]    op_t;

  // Sequencing field, control word bits 20..19
  typedef enum logic [1:0] {
    SEQ_FETCH = 2'd0,
    SEQ_DISP1 = 2'd1,
    SEQ_DISP2 = 2'd2,
    SEQ_NEXT  = 2'd3
  } seq_t;

  // Micro-states
  localparam state_t ST_FETCH  = 4'd0;
  localparam state_t ST_MEMADR = 4'd2;
  localparam state_t ST_MEMRD  = 4'd3;
  localparam state_t ST_MEMWR  = 4'd5;
  localparam state_t ST_EXEC   = 4'd6;
  localparam state_t ST_BRANCH = 4'd8;
  localparam state_t ST_JUMP   = 4'd9;

  // Opcodes
  localparam op_t OP_RTYPE = 6'd0;
  localparam op_t OP_J     = 6'd2;
  localparam op_t OP_BEQ   = 6'd4;
  localparam op_t OP_LW    = 6'd35;
  localparam op_t OP_SW    = 6'd43;

  // Funct codes
  localparam op_t FN_ADD = 6'd32;
  localparam op_t FN_SUB = 6'd34;
  localparam op_t FN_AND = 6'd36;
  localparam op_t FN_OR  = 6'd37;
  localparam op_t FN_SLT = 6'd42;

  // ALUop field values, control word bits 8..6
  localparam logic [2:0] ALUOP_ADD   = 3'd0;
  localparam logic [2:0] ALUOP_SUB   = 3'd1;
  localparam logic [2:0] ALUOP_FUNCT = 3'd2;

  // ALU operation codes
  localparam alu_t ALU_AND = 3'd0;
  localparam alu_t ALU_OR  = 3'd1;
  localparam alu_t ALU_ADD = 3'd2;
  localparam alu_t ALU_SUB = 3'd6;
  localparam alu_t ALU_SLT = 3'd7;

  // Microcode ROM; states past the end read as zero
  function automatic cw_t micro_rom(input state_t st);
    cw_t cw;
    unique case (st)
      4'd0:    cw = 21'h1C5010;  // fetch
      4'd1:    cw = 21'h080030;  // decode
      4'd2:    cw = 21'h100028;  // address calc
      4'd3:    cw = 21'h186000;  // load read
      4'd4:    cw = 21'h010002;  // load write-back
      4'd5:    cw = 21'h000003;  // store
      4'd6:    cw = 21'h180088;  // R-type execute
      4'd7:    cw = 21'h000003;  // R-type completion
      4'd8:    cw = 21'h000A48;  // branch
      4'd9:    cw = 21'h009400;  // jump
      default: cw = '0;
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/mmc_instr_if.sv
`timescale 1ns / 1ps

interface mmc_instr_if;
  logic                          valid;
  logic                          ready;
  logic [mmc_pkg::InstrW-1:0]    instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

>>> rtl/mmc_ctrl_if.sv
`timescale 1ns / 1ps

interface mmc_ctrl_if;
  logic                  valid;
  logic                  ready;
  mmc_pkg::cw_t          control_word;
  mmc_pkg::alu_t         alu_code;
  mmc_pkg::state_t       current_state;

  modport source (output valid, output control_word, output alu_code, output current_state,
                  input ready);
  modport sink   (input valid, input control_word, input alu_code, input current_state,
                  output ready);
endinterface

>>> rtl/mmc_decode.sv
`timescale 1ns / 1ps

module mmc_decode (
  input  mmc_pkg::state_t            state,
  input  logic [mmc_pkg::InstrW-1:0] instruction,
  output mmc_pkg::cw_t               control_word,
  output mmc_pkg::alu_t              alu_code,
  output mmc_pkg::state_t            next_state
);

  mmc_pkg::op_t  opcode;
  mmc_pkg::op_t  funct;
  logic [2:0]    aluop;
  mmc_pkg::seq_t seq;
  mmc_pkg::state_t disp1;
  mmc_pkg::state_t disp2;

  // Look up the microinstruction and split out its fields
  assign control_word = mmc_pkg::micro_rom(state);
  assign opcode       = instruction[31:26];
  assign funct        = instruction[5:0];
  assign aluop        = control_word[8:6];
  assign seq          = mmc_pkg::seq_t'(control_word[20:19]);

  // ALU control; undefined ALUop or funct falls back to add
  always_comb begin
    unique case (aluop)
      mmc_pkg::ALUOP_SUB: alu_code = mmc_pkg::ALU_SUB;
      mmc_pkg::ALUOP_FUNCT: begin
        unique case (funct)
          mmc_pkg::FN_ADD: alu_code = mmc_pkg::ALU_ADD;
          mmc_pkg::FN_SUB: alu_code = mmc_pkg::ALU_SUB;
          mmc_pkg::FN_AND: alu_code = mmc_pkg::ALU_AND;
          mmc_pkg::FN_OR:  alu_code = mmc_pkg::ALU_OR;
          mmc_pkg::FN_SLT: alu_code = mmc_pkg::ALU_SLT;
          default:         alu_code = mmc_pkg::ALU_ADD;
        endcase
      end
      default: alu_code = mmc_pkg::ALU_ADD;
    endcase
  end

  // Dispatch tables; an unlisted opcode returns to fetch
  always_comb begin
    unique case (opcode)
      mmc_pkg::OP_RTYPE: disp1 = mmc_pkg::ST_EXEC;
      mmc_pkg::OP_J:     disp1 = mmc_pkg::ST_JUMP;
      mmc_pkg::OP_BEQ:   disp1 = mmc_pkg::ST_BRANCH;
      mmc_pkg::OP_LW,
      mmc_pkg::OP_SW:    disp1 = mmc_pkg::ST_MEMADR;
      default:           disp1 = mmc_pkg::ST_FETCH;
    endcase
    unique case (opcode)
      mmc_pkg::OP_LW: disp2 = mmc_pkg::ST_MEMRD;
      mmc_pkg::OP_SW: disp2 = mmc_pkg::ST_MEMWR;
      default:        disp2 = mmc_pkg::ST_FETCH;
    endcase
  end

  // Pick the next micro-state
  always_comb begin
    unique case (seq)
      mmc_pkg::SEQ_DISP1: next_state = disp1;
      mmc_pkg::SEQ_DISP2: next_state = disp2;
      mmc_pkg::SEQ_NEXT:  next_state = state + mmc_pkg::StateW'(1);
      default:            next_state = mmc_pkg::ST_FETCH;
    endcase
  end

endmodule

>>> rtl/multicycle_microprogrammed_control_core.sv
`timescale 1ns / 1ps
// Datapath: an accepted instruction beat goes to the input register, then its result
// beat to the result register, around one level of ROM and dispatch decode.
// Throughput: one beat per cycle unless ctrl_ch stalls; result register frees input.
// Reset: rst (synchronous) clears both valid flags and sets the micro-state to fetch.

module multicycle_microprogrammed_control_core (
  input  logic              clk,
  input  logic              rst,
  mmc_instr_if.sink         instr_ch,
  mmc_ctrl_if.source        ctrl_ch
);

  logic                          in_valid;
  logic [mmc_pkg::InstrW-1:0]    in_instr;
  logic                          out_valid;
  mmc_pkg::cw_t                  out_cw;
  mmc_pkg::alu_t                 out_alu;
  mmc_pkg::state_t               out_state;
  mmc_pkg::state_t               micro_state;

  mmc_pkg::cw_t                  dec_cw;
  mmc_pkg::alu_t                 dec_alu;
  mmc_pkg::state_t               micro_state_next;
  logic                          advance;

  // Move a beat into the result register when it is empty or being drained
  assign advance        = in_valid && (!out_valid || ctrl_ch.ready);
  assign instr_ch.ready = !in_valid || advance;

  mmc_decode u_decode (
    .state        (micro_state),
    .instruction  (in_instr),
    .control_word (dec_cw),
    .alu_code     (dec_alu),
    .next_state   (micro_state_next)
  );

  // Capture the incoming instruction beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (instr_ch.ready) begin
      in_valid <= instr_ch.valid;
    end
    if (instr_ch.valid && instr_ch.ready) begin
      in_instr <= instr_ch.instruction;
    end
  end

  // Advance the micro-state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      micro_state <= mmc_pkg::ST_FETCH;
    end else if (advance) begin
      out_valid   <= 1'b1;
      micro_state <= micro_state_next;
    end else if (ctrl_ch.ready) begin
      out_valid   <= 1'b0;
    end
    if (advance) begin
      out_cw    <= dec_cw;
      out_alu   <= dec_alu;
      out_state <= micro_state;
    end
  end

  assign ctrl_ch.valid         = out_valid;
  assign ctrl_ch.control_word  = out_cw;
  assign ctrl_ch.alu_code      = out_alu;
  assign ctrl_ch.current_state = out_state;

endmodule
